[hw/rtl/five_point_smoothing_filter_unit_assert.svh]
// Assertion macros for the five-point smoothing filter.
// Included by the top level; needs nothing else.
`ifndef FIVE_POINT_SMOOTHING_FILTER_UNIT_ASSERT_SVH
`define FIVE_POINT_SMOOTHING_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define FSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled in reset
`define FSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/fsp_pkg.sv]
// Shared types, coefficient tables and divisor helpers of the smoothing filter.
// No dependencies; used by every module of the block.
package fsp_pkg;

  localparam int COEF_W = 8;
  localparam int TAPS   = 5;
  localparam int POS_W  = 3;
  localparam int FILL_W = 3;
  localparam int REM_W  = 9;

  localparam logic [FILL_W-1:0] FILL_EMPTY = 3'd0;
  localparam logic [FILL_W-1:0] FILL_FULL  = 3'd4;
  localparam logic [FILL_W-1:0] FILL_RUN   = 3'd5;

  localparam logic [POS_W-1:0] POS_FIRST = 3'd0;
  localparam logic [POS_W-1:0] POS_MID   = 3'd2;
  localparam logic [POS_W-1:0] POS_LAST  = 3'd4;

  typedef enum logic {
    ORDER_LINEAR = 1'b0,
    ORDER_QUAD   = 1'b1
  } order_t;

  // Doubled divisor used for round-half-away: q = (2*|acc| + d) / (2*d)
  typedef enum logic [2:0] {
    DIV_NONE,
    DIV_10,
    DIV_20,
    DIV_70,
    DIV_140
  } div_t;

  typedef struct packed {
    logic                 valid;
    logic [POS_W-1:0]     pos;
    logic                 raw;
    order_t               order;
    logic                 run_last;
    logic                 series_end;
  } job_t;

  typedef struct packed {
    logic                 accept;
    logic                 last;
    logic [FILL_W-1:0]    fill;
  } seq_stat_t;

  typedef struct packed {
    div_t                 div;
    logic                 neg;
    logic                 run_last;
    logic                 series_end;
  } meta_t;

  localparam logic signed [COEF_W-1:0] LIN_COEF [TAPS][TAPS] = '{
    '{ 8'sd3,  8'sd2,  8'sd1,  8'sd0, -8'sd1},
    '{ 8'sd4,  8'sd3,  8'sd2,  8'sd1,  8'sd0},
    '{ 8'sd1,  8'sd1,  8'sd1,  8'sd1,  8'sd1},
    '{ 8'sd0,  8'sd1,  8'sd2,  8'sd3,  8'sd4},
    '{-8'sd1,  8'sd0,  8'sd1,  8'sd2,  8'sd3}
  };

  localparam logic signed [COEF_W-1:0] QUAD_COEF [TAPS][TAPS] = '{
    '{ 8'sd69,  8'sd4,  -8'sd6,   8'sd4,  -8'sd1},
    '{ 8'sd2,   8'sd27,  8'sd12, -8'sd8,   8'sd2},
    '{-8'sd3,   8'sd12,  8'sd17,  8'sd12, -8'sd3},
    '{ 8'sd2,  -8'sd8,   8'sd12,  8'sd27,  8'sd2},
    '{-8'sd1,   8'sd4,  -8'sd6,   8'sd4,   8'sd69}
  };

  // Weight of one window tap for the point being produced
  function automatic logic signed [COEF_W-1:0] tap_coef(
    input order_t           order,
    input logic             raw,
    input logic [POS_W-1:0] pos,
    input logic [POS_W-1:0] tap
  );
    logic signed [COEF_W-1:0] c;
    if (raw) begin
      c = (tap == pos) ? COEF_W'(1) : '0;
    end else if (order == ORDER_QUAD) begin
      c = QUAD_COEF[pos][tap];
    end else begin
      c = LIN_COEF[pos][tap];
    end
    return c;
  endfunction

  function automatic div_t div_sel(
    input order_t           order,
    input logic             raw,
    input logic [POS_W-1:0] pos
  );
    div_t d;
    if (raw) begin
      d = DIV_NONE;
    end else if (order == ORDER_QUAD) begin
      d = (pos == POS_FIRST || pos == POS_LAST) ? DIV_140 : DIV_70;
    end else begin
      d = (pos == 3'd1 || pos == 3'd3) ? DIV_20 : DIV_10;
    end
    return d;
  endfunction

  function automatic logic [REM_W-1:0] div_den(input div_t div);
    logic [REM_W-1:0] v;
    unique case (div)
      DIV_10:   v = 9'd10;
      DIV_20:   v = 9'd20;
      DIV_70:   v = 9'd70;
      DIV_140:  v = 9'd140;
      DIV_NONE: v = 9'd0;
      default:  v = 9'd0;
    endcase
    return v;
  endfunction

  function automatic logic [REM_W-1:0] div_half(input div_t div);
    return div_den(div) >> 1;
  endfunction

endpackage

[hw/rtl/fsp_cell.sv]
// One window cell: holds a sample and forms its weighted tap product.
// Depends on fsp_pkg.
module fsp_cell #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                         clk,
  input  logic                                         load_en,
  input  logic signed [SAMPLE_WIDTH-1:0]               d_in,
  input  logic signed [fsp_pkg::COEF_W-1:0]            coef,
  output logic signed [SAMPLE_WIDTH-1:0]               q_out,
  output logic signed [SAMPLE_WIDTH+fsp_pkg::COEF_W-1:0] prod
);
  import fsp_pkg::*;

  localparam int PROD_W = SAMPLE_WIDTH + COEF_W;

  logic signed [SAMPLE_WIDTH-1:0] sample_r;

  // Take the neighbor's sample when the window moves
  always_ff @(posedge clk) begin
    if (load_en) begin
      sample_r <= d_in;
    end
  end

  assign q_out = sample_r;

  // Weight the held sample; a tap with zero weight contributes nothing,
  // even while its cell has not been loaded yet
  assign prod = (coef == '0) ? '0 : PROD_W'(sample_r) * PROD_W'(coef);

endmodule

[hw/rtl/fsp_seq.sv]
// Item sequencer: tracks fill state, holds the current item and issues one
// job per cycle (if job_ready) for each owed position. Depends on fsp_pkg.
module fsp_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  input  fsp_pkg::order_t     order,
  input  logic                job_ready,
  output logic                in_ready,
  output logic                shift_en,
  output fsp_pkg::job_t       job,
  output fsp_pkg::seq_stat_t  stat
);
  import fsp_pkg::*;

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              cur_v_r, cur_v_nxt;
  logic              cur_none_r, cur_raw_r, cur_last_r;
  order_t            cur_order_r;
  logic [POS_W-1:0]  cur_k_r, cur_k_nxt, cur_end_r;

  logic              accept, issue, retire;
  logic [POS_W-1:0]  start_k, end_k;
  logic              none_c, raw_c;

  // Plan the positions owed by an arriving item
  always_comb begin
    start_k = POS_MID;
    end_k   = POS_MID;
    none_c  = 1'b0;
    raw_c   = 1'b0;
    if (fill_r < FILL_FULL) begin
      raw_c = 1'b1;
      if (in_last) begin
        start_k = POS_LAST - fill_r;
        end_k   = POS_LAST;
      end else begin
        none_c = 1'b1;
      end
    end else begin
      start_k = (fill_r == FILL_FULL) ? POS_FIRST : POS_MID;
      end_k   = in_last ? POS_LAST : POS_MID;
    end
  end

  // Handshake and job issue
  assign issue    = cur_v_r && !cur_none_r && job_ready;
  assign retire   = cur_v_r && (cur_none_r || (issue && cur_k_r == cur_end_r));
  assign in_ready = !cur_v_r || retire;
  assign accept   = in_valid && in_ready;
  assign shift_en = retire;

  // Next fill count and current-item state
  always_comb begin
    priority if (in_last) begin
      fill_nxt = FILL_EMPTY;
    end else if (fill_r < FILL_FULL) begin
      fill_nxt = fill_r + 3'd1;
    end else begin
      fill_nxt = FILL_RUN;
    end

    cur_v_nxt = cur_v_r;
    cur_k_nxt = cur_k_r;
    if (retire) begin
      cur_v_nxt = 1'b0;
    end
    if (issue) begin
      cur_k_nxt = cur_k_r + 3'd1;
    end
    if (accept) begin
      cur_v_nxt = 1'b1;
      cur_k_nxt = start_k;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= FILL_EMPTY;
      cur_v_r     <= 1'b0;
      cur_k_r     <= POS_FIRST;
      cur_end_r   <= POS_FIRST;
      cur_none_r  <= 1'b0;
      cur_raw_r   <= 1'b0;
      cur_last_r  <= 1'b0;
      cur_order_r <= ORDER_LINEAR;
    end else begin
      cur_v_r <= cur_v_nxt;
      cur_k_r <= cur_k_nxt;
      if (accept) begin
        fill_r      <= fill_nxt;
        cur_end_r   <= end_k;
        cur_none_r  <= none_c;
        cur_raw_r   <= raw_c;
        cur_last_r  <= in_last;
        cur_order_r <= order;
      end
    end
  end

  // Job toward the arithmetic pipeline
  always_comb begin
    job.valid      = cur_v_r && !cur_none_r;
    job.pos        = cur_k_r;
    job.raw        = cur_raw_r;
    job.order      = cur_order_r;
    job.run_last   = (cur_k_r == cur_end_r);
    job.series_end = cur_last_r && (cur_k_r == POS_LAST);
  end

  assign stat.accept = accept;
  assign stat.last   = in_last;
  assign stat.fill   = fill_r;

endmodule

[hw/rtl/fsp_arith.sv]
// Sum, round-divide and saturate pipeline for the smoothing filter.
// Seven stages with per-stage valid; depends on fsp_pkg.
module fsp_arith #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  fsp_pkg::job_t                                  job,
  input  logic signed [SAMPLE_WIDTH+fsp_pkg::COEF_W-1:0] prod [fsp_pkg::TAPS],
  output logic                                           job_ready,
  output logic                                           out_valid,
  input  logic                                           out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]                 smoothed,
  output logic                                           run_last,
  output logic                                           series_end
);
  import fsp_pkg::*;

  localparam int STAGES     = 7;
  localparam int ACC_W      = SAMPLE_WIDTH + COEF_W;
  localparam int M_W        = ACC_W - 3;
  localparam int LO_W       = ACC_W / 2;
  localparam int HI_W       = ACC_W - LO_W;
  localparam int PL_W       = LO_W + M_W;
  localparam int PH_W       = HI_W + M_W;
  localparam int FULL_W     = ACC_W + M_W;
  localparam int DEN_PROD_W = ACC_W + REM_W;

  // Reciprocals floor(2^ACC_W / den); one correction step follows
  localparam logic [M_W-1:0] RCP_10  = M_W'((64'd1 << ACC_W) / 64'(div_den(DIV_10)));
  localparam logic [M_W-1:0] RCP_20  = M_W'((64'd1 << ACC_W) / 64'(div_den(DIV_20)));
  localparam logic [M_W-1:0] RCP_70  = M_W'((64'd1 << ACC_W) / 64'(div_den(DIV_70)));
  localparam logic [M_W-1:0] RCP_140 = M_W'((64'd1 << ACC_W) / 64'(div_den(DIV_140)));

  localparam logic [ACC_W-1:0] SAT_POS = ACC_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
  localparam logic [ACC_W-1:0] SAT_NEG = ACC_W'(64'd1 << (SAMPLE_WIDTH - 1));
  localparam logic [SAMPLE_WIDTH-1:0] SMP_MIN = SAMPLE_WIDTH'(64'd1 << (SAMPLE_WIDTH - 1));

  logic [STAGES-1:0] v_r, en;
  meta_t             m_r [STAGES];

  logic signed [ACC_W-1:0] p0_r [TAPS];
  logic signed [ACC_W-1:0] acc1_r;
  logic [ACC_W-1:0]        num2_r, num3_r, num4_r;
  logic [PL_W-1:0]         pl3_r;
  logic [PH_W-1:0]         ph3_r;
  logic [ACC_W-1:0]        q4_r, q5_r;
  logic [REM_W-1:0]        rem5_r;
  logic [SAMPLE_WIDTH-1:0] sm6_r;

  logic signed [ACC_W-1:0] tap_sum;
  logic [ACC_W-1:0]        mag, num_c;
  logic [M_W-1:0]          rcp;
  logic [FULL_W-1:0]       full;
  logic [ACC_W-1:0]        q_est;
  logic [DEN_PROD_W-1:0]   den_prod;
  logic [ACC_W-1:0]        q_fix;
  logic [SAMPLE_WIDTH-1:0] sat_c;
  meta_t                   m_neg;

  // Stage enables: a stage loads when empty or when it drains
  always_comb begin
    en[STAGES-1] = !v_r[STAGES-1] || out_ready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign job_ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= job.valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // Stage 1: sum of tap products
  always_comb begin
    tap_sum = '0;
    for (int i = 0; i < TAPS; i++) begin
      tap_sum = tap_sum + p0_r[i];
    end
  end

  // Stage 2: doubled magnitude plus half divisor
  always_comb begin
    mag = acc1_r[ACC_W-1] ? ACC_W'(-acc1_r) : ACC_W'(acc1_r);
    if (m_r[1].div == DIV_NONE) begin
      num_c = mag;
    end else begin
      num_c = (mag << 1) + ACC_W'(div_half(m_r[1].div));
    end
    m_neg     = m_r[1];
    m_neg.neg = acc1_r[ACC_W-1];
  end

  // Stage 3: reciprocal pick
  always_comb begin
    unique case (m_r[2].div)
      DIV_10:   rcp = RCP_10;
      DIV_20:   rcp = RCP_20;
      DIV_70:   rcp = RCP_70;
      DIV_140:  rcp = RCP_140;
      DIV_NONE: rcp = '0;
      default:  rcp = '0;
    endcase
  end

  // Stage 4: join partial products into the quotient estimate
  always_comb begin
    full = (FULL_W'(ph3_r) << LO_W) + FULL_W'(pl3_r);
    if (m_r[3].div == DIV_NONE) begin
      q_est = num3_r;
    end else begin
      q_est = ACC_W'(full >> ACC_W);
    end
  end

  // Stage 5: remainder of the estimate
  assign den_prod = DEN_PROD_W'(q4_r) * DEN_PROD_W'(div_den(m_r[4].div));

  // Stage 6: correct by one, restore sign, clamp
  always_comb begin
    if (m_r[5].div != DIV_NONE && rem5_r >= div_den(m_r[5].div)) begin
      q_fix = q5_r + ACC_W'(1);
    end else begin
      q_fix = q5_r;
    end
    priority if (m_r[5].neg && q_fix >= SAT_NEG) begin
      sat_c = SMP_MIN;
    end else if (m_r[5].neg) begin
      sat_c = SAMPLE_WIDTH'(-q_fix);
    end else if (q_fix > SAT_POS) begin
      sat_c = SAT_POS[SAMPLE_WIDTH-1:0];
    end else begin
      sat_c = q_fix[SAMPLE_WIDTH-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < TAPS; i++) begin
        p0_r[i] <= prod[i];
      end
      m_r[0] <= '{div: div_sel(job.order, job.raw, job.pos), neg: 1'b0,
                  run_last: job.run_last, series_end: job.series_end};
    end
    if (en[1]) begin
      acc1_r <= tap_sum;
      m_r[1] <= m_r[0];
    end
    if (en[2]) begin
      num2_r <= num_c;
      m_r[2] <= m_neg;
    end
    if (en[3]) begin
      pl3_r  <= PL_W'(num2_r[LO_W-1:0]) * PL_W'(rcp);
      ph3_r  <= PH_W'(num2_r[ACC_W-1:LO_W]) * PH_W'(rcp);
      num3_r <= num2_r;
      m_r[3] <= m_r[2];
    end
    if (en[4]) begin
      q4_r   <= q_est;
      num4_r <= num3_r;
      m_r[4] <= m_r[3];
    end
    if (en[5]) begin
      q5_r   <= q4_r;
      rem5_r <= REM_W'(DEN_PROD_W'(num4_r) - den_prod);
      m_r[5] <= m_r[4];
    end
    if (en[6]) begin
      sm6_r  <= sat_c;
      m_r[6] <= m_r[5];
    end
  end

  assign out_valid  = v_r[STAGES-1];
  assign smoothed   = sm6_r;
  assign run_last   = m_r[STAGES-1].run_last;
  assign series_end = m_r[STAGES-1].series_end;

endmodule

[hw/rtl/five_point_smoothing_filter_unit.sv]
// Channel | dir | handshake            | payload
// in_     | in  | in_tvalid/in_tready  | in_tdata = sample, in_tlast = series_last
// out_    | out | out_tvalid/out_tready| out_tdata = smoothed, out_tlast = run_last,
//         |     |                      | out_tuser = series_end
// cfg_    | in  | cfg_wr_en            | cfg_wr_data = smoothing_order
//
// Cycles: one item per cycle while each item yields at most one result and the
// output does not stall. An item yielding more than one result (fifth sample of a
// series, final sample, short series) holds in_tready low until its last result is
// issued: the sequencer issues one result per cycle, unless stalled, into a
// single shared divide pipeline.
// Reset: synchronous, active low; clears fill count, mode and pipeline valids.
// Stalls: out_tready low backs up through the pipeline into in_tready.
// Depends on fsp_pkg, fsp_seq, fsp_cell, fsp_arith and the assertion header.
module five_point_smoothing_filter_unit #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  in_tdata,   // [SAMPLE_WIDTH-1:0] sample
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]  out_tdata,  // [SAMPLE_WIDTH-1:0] smoothed
  output logic                               out_tlast,
  output logic                               out_tuser   // [0] series_end
);
  import fsp_pkg::*;

  `include "five_point_smoothing_filter_unit_assert.svh"

  localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int PROD_W  = SAMPLE_WIDTH + COEF_W;

  order_t    order_r;
  job_t      job;
  seq_stat_t stat;
  logic      shift_en, job_ready;

  logic signed [SAMPLE_WIDTH-1:0] cell_q [TAPS];
  logic signed [PROD_W-1:0]       cell_prod [TAPS];
  logic signed [SAMPLE_WIDTH-1:0] smoothed;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_LINEAR;
    end else if (cfg_wr_en) begin
      order_r <= order_t'(cfg_wr_data);
    end
  end

  fsp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_last   (in_tlast),
    .order     (order_r),
    .job_ready (job_ready),
    .in_ready  (in_tready),
    .shift_en  (shift_en),
    .job       (job),
    .stat      (stat)
  );

  // Window cells: newest item enters the top cell, older ones move down
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    if (i == TAPS - 1) begin : g_head
      fsp_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
        .clk     (clk),
        .load_en (stat.accept),
        .d_in    (in_tdata[SAMPLE_WIDTH-1:0]),
        .coef    (tap_coef(job.order, job.raw, job.pos, POS_W'(i))),
        .q_out   (cell_q[i]),
        .prod    (cell_prod[i])
      );
    end else begin : g_body
      fsp_cell #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_cell (
        .clk     (clk),
        .load_en (shift_en),
        .d_in    (cell_q[i+1]),
        .coef    (tap_coef(job.order, job.raw, job.pos, POS_W'(i))),
        .q_out   (cell_q[i]),
        .prod    (cell_prod[i])
      );
    end
  end

  fsp_arith #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_arith (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (job),
    .prod       (cell_prod),
    .job_ready  (job_ready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .smoothed   (smoothed),
    .run_last   (out_tlast),
    .series_end (out_tuser)
  );

  assign out_tdata = TDATA_W'($unsigned(smoothed));

  // Checks
  `FSP_ASSERT_IMPL(a_series_end_closes_run, clk, rst_n, out_tvalid && out_tuser, out_tlast, "series end without run end")
  `FSP_ASSERT_NEXT(a_last_clears_fill, clk, rst_n, stat.accept && stat.last, stat.fill == FILL_EMPTY, "fill count not cleared after series end")
  `FSP_ASSERT_NEXT(a_fill_issues_nothing, clk, rst_n, stat.accept && !stat.last && (stat.fill < FILL_FULL), !job.valid, "job issued while filling window")

endmodule

[sim/five_point_smoothing_filter_unit_tb.sv]
// Self-checking bench for the five-point smoothing filter: streams sample series
// through the stream ports and checks each smoothed item against its own model.
// Depends on fsp_pkg and the five_point_smoothing_filter_unit top level.
`timescale 1ns / 100ps

module five_point_smoothing_filter_unit_tb;

  localparam int SW          = 16;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_WAIT  = 12;
  localparam longint SAT_MAX = 32767;
  localparam longint SAT_MIN = -32768;

  // Weights and divisors per output position, oldest tap first
  localparam int LINEAR_WEIGHTS [5][5] = '{
    '{ 3, 2, 1, 0, -1},
    '{ 4, 3, 2, 1,  0},
    '{ 1, 1, 1, 1,  1},
    '{ 0, 1, 2, 3,  4},
    '{-1, 0, 1, 2,  3}
  };
  localparam int LINEAR_DIVS [5] = '{5, 10, 5, 10, 5};
  localparam int QUAD_WEIGHTS [5][5] = '{
    '{69,  4, -6,  4, -1},
    '{ 2, 27, 12, -8,  2},
    '{-3, 12, 17, 12, -3},
    '{ 2, -8, 12, 27,  2},
    '{-1,  4, -6,  4, 69}
  };
  localparam int QUAD_DIVS [5] = '{70, 35, 35, 35, 70};

  typedef struct {
    logic signed [SW-1:0] smoothed;
    logic                 run_last;
    logic                 series_end;
  } smooth_result_t;

  logic          clk;
  logic          rst_n;
  logic          cfg_wr_en;
  logic          cfg_wr_data;
  logic          in_tvalid;
  logic          in_tready;
  logic [SW-1:0] in_tdata;
  logic          in_tlast;
  logic          out_tvalid;
  logic          out_tready;
  logic [SW-1:0] out_tdata;
  logic          out_tlast;
  logic          out_tuser;

  // Model state
  logic signed [SW-1:0] model_window [4];
  int                   model_fill;
  fsp_pkg::order_t      model_order;
  smooth_result_t       expected_results [$];

  int mismatch_count;
  int cycle_count;
  int burst_mode;
  int burst_left;
  int rx_mode;
  int hold_req;
  int samples_sent;

  five_point_smoothing_filter_unit #(.SAMPLE_WIDTH(SW)) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort the run at the cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Weighted sum, round half away from zero, saturate
  function automatic logic signed [SW-1:0] smoothed_point(input fsp_pkg::order_t ord,
                                                          input longint win [5],
                                                          input int pos);
    longint acc;
    longint mag;
    longint q;
    longint d;
    int     i;
    acc = 0;
    for (i = 0; i < 5; i++) begin
      if (ord == fsp_pkg::ORDER_QUAD) begin
        acc += longint'(QUAD_WEIGHTS[pos][i]) * win[i];
      end else begin
        acc += longint'(LINEAR_WEIGHTS[pos][i]) * win[i];
      end
    end
    d = (ord == fsp_pkg::ORDER_QUAD) ? QUAD_DIVS[pos] : LINEAR_DIVS[pos];
    mag = (acc < 0) ? -acc : acc;
    q = (2 * mag + d) / (2 * d);
    if (acc < 0) q = -q;
    if (q > SAT_MAX) q = SAT_MAX;
    if (q < SAT_MIN) q = SAT_MIN;
    return q[SW-1:0];
  endfunction

  function automatic smooth_result_t make_result(input logic signed [SW-1:0] v,
                                                 input logic series_end);
    smooth_result_t r;
    r.smoothed   = v;
    r.run_last   = 1'b0;
    r.series_end = series_end;
    return r;
  endfunction

  // Advance the model by one accepted item and queue what it yields
  task automatic predict_sample(input logic signed [SW-1:0] s, input logic last);
    smooth_result_t batch [$];
    longint         win [5];
    int             i;
    if (model_fill < 4) begin
      if (!last) begin
        model_window[model_fill] = s;
        model_fill++;
        return;
      end
      // Short series: pass through raw
      for (i = 0; i < model_fill; i++) begin
        batch.push_back(make_result(model_window[i], 1'b0));
      end
      batch.push_back(make_result(s, 1'b1));
      model_fill = 0;
    end else begin
      for (i = 0; i < 4; i++) win[i] = longint'(model_window[i]);
      win[4] = longint'(s);
      if (model_fill == 4) begin
        batch.push_back(make_result(smoothed_point(model_order, win, 0), 1'b0));
        batch.push_back(make_result(smoothed_point(model_order, win, 1), 1'b0));
      end
      batch.push_back(make_result(smoothed_point(model_order, win, 2), 1'b0));
      if (last) begin
        batch.push_back(make_result(smoothed_point(model_order, win, 3), 1'b0));
        batch.push_back(make_result(smoothed_point(model_order, win, 4), 1'b1));
        model_fill = 0;
      end else begin
        for (i = 0; i < 4; i++) model_window[i] = win[i + 1][SW-1:0];
        model_fill = 5;
      end
    end
    batch[batch.size() - 1].run_last = 1'b1;
    foreach (batch[k]) expected_results.push_back(batch[k]);
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    smooth_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: smoothed=%0d run_last=%0b series_end=%0b",
               $signed(out_tdata), out_tlast, out_tuser);
        mismatch_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata !== exp_r.smoothed) begin
          $error("smoothed: expected %0d, actual %0d", exp_r.smoothed, $signed(out_tdata));
          mismatch_count++;
        end
        if (out_tlast !== exp_r.run_last) begin
          $error("run_last: expected %0b, actual %0b", exp_r.run_last, out_tlast);
          mismatch_count++;
        end
        if (out_tuser !== exp_r.series_end) begin
          $error("series_end: expected %0b, actual %0b", exp_r.series_end, out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // Drive out_tready: long hold on request, else by the current mode
  initial begin
    int       hold_left;
    int       reroll;
    bit [7:0] pattern;
    hold_left = 0;
    reroll = 0;
    pattern = 8'hb5;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (reroll == 0) begin
        pattern = 8'($urandom) | 8'h01;
        reroll = $urandom_range(16, 64);
      end
      reroll--;
      pattern = {pattern[6:0], pattern[7]};
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else begin
        case (rx_mode)
          0:       out_tready = 1'b1;
          1:       out_tready = ($urandom_range(0, 3) != 0);
          default: out_tready = pattern[0];
        endcase
      end
    end
  end

  // Offer one item and hold it until accepted; insert burst gaps
  task automatic send_sample(input logic signed [SW-1:0] s, input logic last);
    int gap;
    if (burst_mode != 0 && burst_left == 0) begin
      gap = $urandom_range(1, 7);
      burst_left = $urandom_range(1, 9);
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = s;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_sample(s, last);
    samples_sent++;
  endtask

  // Drop valid, wait for every expected result, then let the pipeline settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write the mode register while the block is idle
  task automatic set_order(input fsp_pkg::order_t ord);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = ord;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    model_order = ord;
  endtask

  function automatic logic signed [SW-1:0] rand_sample();
    logic signed [SW-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = 16'sh7fff;
      1:       v = 16'sh8000;
      2, 3:    v = SW'($urandom_range(0, 200)) - 16'sd100;
      4:       v = $urandom_range(0, 1) ? 16'sh7fff - SW'($urandom_range(0, 15))
                                        : 16'sh8000 + SW'($urandom_range(0, 15));
      default: v = SW'($urandom);
    endcase
    return v;
  endfunction

  task automatic send_random_series(input int len);
    int i;
    for (i = 0; i < len; i++) send_sample(rand_sample(), i == len - 1);
  endtask

  // Series of one, two and four samples come back raw
  task automatic test_short_series();
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'shffff, 1'b0);
    send_sample(16'sh0001, 1'b1);
  endtask

  // Ties at .5 round away from zero on both signs
  task automatic test_rounding_ties();
    send_sample(16'sd1, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd2, 1'b1);
  endtask

  // Quadratic series of exactly five with extreme samples; the first point saturates
  task automatic test_quad_five_saturation();
    set_order(fsp_pkg::ORDER_QUAD);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b1);
  endtask

  // Switch mode inside a series; later points use the new mode
  task automatic test_mode_change_mid_series();
    set_order(fsp_pkg::ORDER_LINEAR);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 1'b0);
    send_sample(16'sh8000, 1'b0);
    set_order(fsp_pkg::ORDER_QUAD);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7fff, 1'b1);
  endtask

  // Hold the receiver off while the sender keeps offering items
  task automatic test_input_backpressure();
    wait_idle();
    burst_mode = 0;
    rx_mode = 0;
    hold_req = 300;
    send_random_series(30);
    wait_idle();
  endtask

  // Random series lengths, modes and idling on both sides
  task automatic test_random_series();
    int len;
    int split;
    int i;
    while (samples_sent < 100) begin
      case ($urandom_range(0, 9))
        0, 1:    len = $urandom_range(1, 4);
        8:       len = $urandom_range(11, 20);
        9:       len = 5;
        default: len = $urandom_range(5, 10);
      endcase
      burst_mode = $urandom_range(0, 2);
      rx_mode = $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) begin
        set_order(fsp_pkg::order_t'($urandom_range(0, 1)));
      end
      if (len > 5 && $urandom_range(0, 5) == 0) begin
        // Mode change partway through a series
        split = $urandom_range(1, len - 1);
        for (i = 0; i < split; i++) send_sample(rand_sample(), 1'b0);
        set_order(fsp_pkg::order_t'($urandom_range(0, 1)));
        for (i = split; i < len; i++) send_sample(rand_sample(), i == len - 1);
      end else begin
        send_random_series(len);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    model_fill   = 0;
    model_order  = fsp_pkg::ORDER_LINEAR;
    foreach (model_window[i]) model_window[i] = '0;
    mismatch_count = 0;
    cycle_count  = 0;
    burst_mode   = 0;
    burst_left   = 0;
    rx_mode      = 0;
    hold_req     = 0;
    samples_sent = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_short_series();
    test_rounding_ties();
    test_quad_five_saturation();
    test_mode_change_mid_series();
    test_input_backpressure();
    test_random_series();

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[five_point_smoothing_filter_unit.f]
+incdir+hw/rtl
hw/rtl/fsp_pkg.sv
hw/rtl/fsp_cell.sv
hw/rtl/fsp_seq.sv
hw/rtl/fsp_arith.sv
hw/rtl/five_point_smoothing_filter_unit.sv
sim/five_point_smoothing_filter_unit_tb.sv
